// ===== hdl/ddpi_pkg.sv =====
package ddpi_pkg;

   typedef enum logic [1:0] {
      OP_TICK,
      OP_RESET,
      OP_SET_POSE,
      OP_SET_STOP
   } op_type;

   localparam int CSR_IDX_W = 8;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_TIME       = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INITIAL_X       = 8'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INITIAL_Y       = 8'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_INITIAL_HEADING = 8'd3;

   localparam logic [15:0] STEP_TIME_RESET = 16'd2621;

   localparam int CORDIC_STEPS = 14;
   localparam int ITER_W       = 4;

   typedef enum logic [2:0] {
      A_LIN,
      A_ANG,
      A_COS,
      A_SIN,
      A_WLO,
      A_WHI
   } a_sel_type;

   typedef enum logic [1:0] {
      B_DT,
      B_VLO,
      B_VHI,
      B_K
   } b_sel_type;

   typedef enum logic [1:0] {
      ACC_HOLD,
      ACC_LOAD_POS,
      ACC_LOAD_HEAD,
      ACC_ADD_HI
   } acc_op_type;

   typedef enum logic [2:0] {
      SV_NONE,
      SV_VDT,
      SV_WDT,
      SV_X,
      SV_Y,
      SV_H,
      SV_MISC
   } save_type;

   typedef enum logic [1:0] {
      CR_NONE,
      CR_INIT,
      CR_ITER
   } cordic_op_type;

   typedef enum logic [1:0] {
      JC_NEXT,
      JC_NOT_MOVE,
      JC_LOOP,
      JC_ALWAYS
   } jump_type;

   localparam int PC_W = 4;

   typedef struct packed {
      logic          mul_en;
      a_sel_type     a_sel;
      b_sel_type     b_sel;
      acc_op_type    acc_op;
      save_type      save;
      cordic_op_type cordic;
      jump_type      jump;
      logic [PC_W-1:0] target;
      logic          done;
   } ctrl_type;

   localparam ctrl_type CTRL_NOP = '{
      mul_en: 1'b0,
      a_sel:  A_LIN,
      b_sel:  B_DT,
      acc_op: ACC_HOLD,
      save:   SV_NONE,
      cordic: CR_NONE,
      jump:   JC_NEXT,
      target: '0,
      done:   1'b0
   };

   typedef struct packed {
      logic not_move;
      logic loop_more;
   } cond_type;

   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic [15:0]        heading;
      logic               halted;
   } pose_type;

endpackage

// ===== hdl/ddpi_seq.sv =====
module ddpi_seq (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  ddpi_pkg::cond_type          cond,
   input  logic                        out_free,
   output ddpi_pkg::ctrl_type          ctrl,
   output logic                        busy,
   output logic                        done_fire
);
   import ddpi_pkg::*;

   localparam logic [PC_W-1:0] PC_DISPATCH = 4'd0;
   localparam logic [PC_W-1:0] PC_LOOP     = 4'd3;
   localparam logic [PC_W-1:0] PC_DONE     = 4'd12;
   localparam logic [PC_W-1:0] PC_MISC     = 4'd13;

   function automatic ctrl_type rom(input logic [PC_W-1:0] pc);
      ctrl_type w;
      w = CTRL_NOP;
      case (pc)
         4'd0: begin
            w.cordic = CR_INIT;
            w.mul_en = 1'b1; w.a_sel = A_LIN; w.b_sel = B_DT;
            w.jump = JC_NOT_MOVE; w.target = PC_MISC;
         end
         4'd1: begin
            w.mul_en = 1'b1; w.a_sel = A_ANG; w.b_sel = B_DT;
            w.save = SV_VDT;
         end
         4'd2: begin
            w.save = SV_WDT;
         end
         4'd3: begin
            w.cordic = CR_ITER;
            w.jump = JC_LOOP; w.target = PC_LOOP;
         end
         4'd4: begin
            w.mul_en = 1'b1; w.a_sel = A_COS; w.b_sel = B_VLO;
         end
         4'd5: begin
            w.mul_en = 1'b1; w.a_sel = A_COS; w.b_sel = B_VHI;
            w.acc_op = ACC_LOAD_POS;
         end
         4'd6: begin
            w.mul_en = 1'b1; w.a_sel = A_SIN; w.b_sel = B_VLO;
            w.acc_op = ACC_ADD_HI;
         end
         4'd7: begin
            w.mul_en = 1'b1; w.a_sel = A_SIN; w.b_sel = B_VHI;
            w.acc_op = ACC_LOAD_POS; w.save = SV_X;
         end
         4'd8: begin
            w.mul_en = 1'b1; w.a_sel = A_WLO; w.b_sel = B_K;
            w.acc_op = ACC_ADD_HI;
         end
         4'd9: begin
            w.mul_en = 1'b1; w.a_sel = A_WHI; w.b_sel = B_K;
            w.acc_op = ACC_LOAD_HEAD; w.save = SV_Y;
         end
         4'd10: begin
            w.acc_op = ACC_ADD_HI;
         end
         4'd11: begin
            w.save = SV_H;
         end
         4'd12: begin
            w.done = 1'b1;
         end
         4'd13: begin
            w.save = SV_MISC;
            w.jump = JC_ALWAYS; w.target = PC_DONE;
         end
         default: begin
            w.jump = JC_ALWAYS; w.target = PC_DONE;
         end
      endcase
      return w;
   endfunction

   logic [PC_W-1:0] pc_ff, pc_in;
   logic            busy_ff, busy_in;
   ctrl_type        word;

   assign word      = rom(pc_ff);
   assign ctrl      = busy_ff ? word : CTRL_NOP;
   assign busy      = busy_ff;
   assign done_fire = busy_ff & word.done & out_free;

   always_comb begin
      pc_in   = pc_ff;
      busy_in = busy_ff;
      if (start) begin
         pc_in   = PC_DISPATCH;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (word.done) begin
            if (out_free) begin
               pc_in   = PC_DISPATCH;
               busy_in = 1'b0;
            end
         end else begin
            case (word.jump)
               JC_NEXT:     pc_in = pc_ff + 1'b1;
               JC_NOT_MOVE: pc_in = cond.not_move ? word.target : pc_ff + 1'b1;
               JC_LOOP:     pc_in = cond.loop_more ? word.target : pc_ff + 1'b1;
               JC_ALWAYS:   pc_in = word.target;
               default:     pc_in = pc_ff + 1'b1;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff   <= PC_DISPATCH;
         busy_ff <= 1'b0;
      end else begin
         pc_ff   <= pc_in;
         busy_ff <= busy_in;
      end
   end

endmodule

// ===== hdl/ddpi_cordic.sv =====
module ddpi_cordic (
   input  logic                        clock,
   input  logic                        reset,
   input  ddpi_pkg::cordic_op_type     cmd,
   input  logic [15:0]                 heading,
   output logic signed [15:0]          cos_val,
   output logic signed [15:0]          sin_val,
   output logic                        loop_more
);
   import ddpi_pkg::*;

   localparam logic signed [17:0] GAIN     = 18'sd19898;
   localparam logic signed [17:0] TRIG_MAX = 18'sd32767;
   localparam logic signed [15:0] QUARTER  = 16'sd16384;

   function automatic logic signed [17:0] atan_bam(input logic [ITER_W-1:0] i);
      logic signed [17:0] a;
      case (i)
         4'd0:    a = 18'sd8192;
         4'd1:    a = 18'sd4836;
         4'd2:    a = 18'sd2555;
         4'd3:    a = 18'sd1297;
         4'd4:    a = 18'sd651;
         4'd5:    a = 18'sd326;
         4'd6:    a = 18'sd163;
         4'd7:    a = 18'sd81;
         4'd8:    a = 18'sd41;
         4'd9:    a = 18'sd20;
         4'd10:   a = 18'sd10;
         4'd11:   a = 18'sd5;
         4'd12:   a = 18'sd3;
         4'd13:   a = 18'sd1;
         default: a = 18'sd0;
      endcase
      return a;
   endfunction

   function automatic logic signed [15:0] clamp(input logic signed [17:0] v);
      logic signed [15:0] r;
      if (v > TRIG_MAX) r = 16'sd32767;
      else if (v < -TRIG_MAX) r = -16'sd32767;
      else r = v[15:0];
      return r;
   endfunction

   logic signed [17:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic signed [17:0] xs, ys, xr, yr;
   logic               flip_ff, flip_in;
   logic [ITER_W-1:0]  iter_ff, iter_in;
   logic signed [15:0] hs;
   logic [15:0]        hf;
   logic               far;

   always_comb begin
      hs = signed'(heading);
      hf = heading ^ 16'h8000;
      far = (hs > QUARTER) || (hs < -QUARTER);
      xs = x_ff >>> iter_ff;
      ys = y_ff >>> iter_ff;
      x_in = x_ff;
      y_in = y_ff;
      z_in = z_ff;
      flip_in = flip_ff;
      iter_in = iter_ff;
      case (cmd)
         CR_INIT: begin
            x_in = GAIN;
            y_in = '0;
            z_in = far ? {{2{hf[15]}}, hf} : {{2{hs[15]}}, hs};
            flip_in = far;
            iter_in = '0;
         end
         CR_ITER: begin
            if (!z_ff[17]) begin
               x_in = x_ff - ys;
               y_in = y_ff + xs;
               z_in = z_ff - atan_bam(iter_ff);
            end else begin
               x_in = x_ff + ys;
               y_in = y_ff - xs;
               z_in = z_ff + atan_bam(iter_ff);
            end
            iter_in = iter_ff + 1'b1;
         end
         default: ;
      endcase
   end

   always_comb begin
      xr = flip_ff ? -x_ff : x_ff;
      yr = flip_ff ? -y_ff : y_ff;
   end

   assign cos_val   = clamp(xr);
   assign sin_val   = clamp(yr);
   assign loop_more = iter_ff != ITER_W'(CORDIC_STEPS - 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         iter_ff <= '0;
      end else begin
         iter_ff <= iter_in;
      end
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      flip_ff <= flip_in;
   end

endmodule

// ===== hdl/ddpi_dp.sv =====
module ddpi_dp (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              load,
   input  ddpi_pkg::op_type                  req_op,
   input  logic signed [15:0]                req_lin_vel,
   input  logic signed [15:0]                req_ang_vel,
   input  logic signed [31:0]                req_new_x,
   input  logic signed [31:0]                req_new_y,
   input  logic [15:0]                       req_new_heading,
   input  logic                              req_stop_value,
   input  logic                              csr_we,
   input  logic [ddpi_pkg::CSR_IDX_W-1:0]    csr_idx,
   input  logic [31:0]                       csr_wdata,
   input  ddpi_pkg::ctrl_type                ctrl,
   input  logic signed [15:0]                cos_val,
   input  logic signed [15:0]                sin_val,
   output ddpi_pkg::pose_type                pose,
   output ddpi_pkg::op_type                  cur_op,
   output logic                              not_move
);
   import ddpi_pkg::*;

   localparam int ACC_W = 63;
   localparam logic signed [31:0] RAD_TO_BAM = 32'sd683565277;
   localparam logic signed [ACC_W-1:0] POS_ROUND  = ACC_W'(64'd1 << 26);
   localparam logic signed [ACC_W-1:0] HEAD_ROUND = ACC_W'(64'd1 << 43);

   function automatic logic signed [31:0] sat_add(input logic signed [31:0] p,
                                                  input logic signed [35:0] d);
      logic signed [36:0] s;
      logic signed [31:0] r;
      s = {{5{p[31]}}, p} + {d[35], d};
      if (s[36:31] != {6{s[36]}}) r = s[36] ? 32'sh8000_0000 : 32'sh7fff_ffff;
      else r = s[31:0];
      return r;
   endfunction

   op_type             op_ff;
   logic signed [15:0] lin_ff, ang_ff;
   logic signed [31:0] nx_ff, ny_ff;
   logic [15:0]        nh_ff;
   logic               stop_ff;

   logic [15:0]        step_time_ff;
   logic signed [31:0] init_x_ff, init_y_ff;
   logic [15:0]        init_h_ff;

   logic signed [31:0] x_ff, x_in, y_ff, y_in;
   logic [15:0]        h_ff, h_in;
   logic               halted_ff, halted_in;

   logic signed [31:0] vdt_ff, vdt_in, wdt_ff, wdt_in;
   logic signed [17:0] mul_a;
   logic signed [31:0] mul_b;
   logic signed [49:0] prod, prod_ff;
   logic signed [ACC_W-1:0] acc_ff, acc_in;

   always_comb begin
      case (ctrl.a_sel)
         A_LIN:   mul_a = {{2{lin_ff[15]}}, lin_ff};
         A_ANG:   mul_a = {{2{ang_ff[15]}}, ang_ff};
         A_COS:   mul_a = {{2{cos_val[15]}}, cos_val};
         A_SIN:   mul_a = {{2{sin_val[15]}}, sin_val};
         A_WLO:   mul_a = {2'b00, wdt_ff[15:0]};
         A_WHI:   mul_a = {{2{wdt_ff[31]}}, wdt_ff[31:16]};
         default: mul_a = '0;
      endcase
      case (ctrl.b_sel)
         B_DT:    mul_b = {16'h0000, step_time_ff};
         B_VLO:   mul_b = {16'h0000, vdt_ff[15:0]};
         B_VHI:   mul_b = {{16{vdt_ff[31]}}, vdt_ff[31:16]};
         B_K:     mul_b = RAD_TO_BAM;
         default: mul_b = '0;
      endcase
   end

   assign prod = mul_a * mul_b;

   always_comb begin
      case (ctrl.acc_op)
         ACC_LOAD_POS:  acc_in = {{13{prod_ff[49]}}, prod_ff} + POS_ROUND;
         ACC_LOAD_HEAD: acc_in = {{13{prod_ff[49]}}, prod_ff} + HEAD_ROUND;
         ACC_ADD_HI:    acc_in = acc_ff + {prod_ff[46:0], 16'h0000};
         default:       acc_in = acc_ff;
      endcase
   end

   always_comb begin
      vdt_in    = vdt_ff;
      wdt_in    = wdt_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      h_in      = h_ff;
      halted_in = halted_ff;
      case (ctrl.save)
         SV_VDT: vdt_in = prod_ff[31:0];
         SV_WDT: wdt_in = prod_ff[31:0];
         SV_X:   x_in = sat_add(x_ff, acc_ff[62:27]);
         SV_Y:   y_in = sat_add(y_ff, acc_ff[62:27]);
         SV_H:   h_in = h_ff + acc_ff[59:44];
         SV_MISC: begin
            case (op_ff)
               OP_RESET: begin
                  x_in = init_x_ff;
                  y_in = init_y_ff;
                  h_in = init_h_ff;
               end
               OP_SET_POSE: begin
                  x_in = nx_ff;
                  y_in = ny_ff;
                  h_in = nh_ff;
               end
               OP_SET_STOP: halted_in = stop_ff;
               default: ;
            endcase
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_time_ff <= STEP_TIME_RESET;
         init_x_ff    <= '0;
         init_y_ff    <= '0;
         init_h_ff    <= '0;
         x_ff         <= '0;
         y_ff         <= '0;
         h_ff         <= '0;
         halted_ff    <= 1'b0;
         op_ff        <= OP_TICK;
      end else begin
         if (csr_we) begin
            case (csr_idx)
               CSR_STEP_TIME:       step_time_ff <= csr_wdata[15:0];
               CSR_INITIAL_X:       init_x_ff    <= csr_wdata;
               CSR_INITIAL_Y:       init_y_ff    <= csr_wdata;
               CSR_INITIAL_HEADING: init_h_ff    <= csr_wdata[15:0];
               default: ;
            endcase
         end
         x_ff      <= x_in;
         y_ff      <= y_in;
         h_ff      <= h_in;
         halted_ff <= halted_in;
         if (load) begin
            op_ff <= req_op;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         lin_ff  <= req_lin_vel;
         ang_ff  <= req_ang_vel;
         nx_ff   <= req_new_x;
         ny_ff   <= req_new_y;
         nh_ff   <= req_new_heading;
         stop_ff <= req_stop_value;
      end
      if (ctrl.mul_en) begin
         prod_ff <= prod;
      end
      vdt_ff <= vdt_in;
      wdt_ff <= wdt_in;
      acc_ff <= acc_in;
   end

   assign pose.x       = x_ff;
   assign pose.y       = y_ff;
   assign pose.heading = h_ff;
   assign pose.halted  = halted_ff;
   assign cur_op       = op_ff;
   assign not_move     = (op_ff != OP_TICK) || halted_ff;

endmodule

// ===== hdl/diff_drive_pose_integrator_unit.sv =====
// channel   ports                                 payload
// req       req_tvalid/tready, tdata, tuser       tick, reset, set pose, set stop
// rsp       rsp_tvalid/tready, tdata, tuser       pose after the request, op echo
// csr       csr_valid/ready, csr_index, csr_data  step time and initial pose
//
// a moving tick runs 3 setup steps, then 14 cordic iterations in one looping microcode
// step, then 9 steps through the shared 18x32 multiplier and the 63-bit accumulator
// reset, set pose, set stop and a halted tick go from dispatch to the misc step, then done
// synchronous reset clears control state, pose, stop flag, initial pose; step time to 2621
// one request at a time; a waiting result stalls only the final step
module diff_drive_pose_integrator_unit (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [119:0] req_tdata,   // lin_vel, ang_vel, new_x, new_y, new_heading, stop_value
   input  logic [1:0]   req_tuser,   // op
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [87:0]  rsp_tdata,   // pos_x, pos_y, heading, is_stopped
   output logic [1:0]   rsp_tuser,   // done_op
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [7:0]   csr_index,
   input  logic [31:0]  csr_data
);
   import ddpi_pkg::*;

   logic               busy, done_fire, out_free, accept, loop_more, not_move;
   ctrl_type           ctrl;
   cond_type           cond;
   pose_type           pose;
   op_type             cur_op;
   logic signed [15:0] cos_val, sin_val;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [87:0]        rsp_data_ff;
   logic [1:0]         rsp_user_ff;

   assign req_tready = !busy;
   assign csr_ready  = 1'b1;
   assign accept     = req_tvalid & req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign cond       = '{not_move: not_move, loop_more: loop_more};

   ddpi_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .start     (accept),
      .cond      (cond),
      .out_free  (out_free),
      .ctrl      (ctrl),
      .busy      (busy),
      .done_fire (done_fire)
   );

   ddpi_cordic u_cordic (
      .clock     (clock),
      .reset     (reset),
      .cmd       (ctrl.cordic),
      .heading   (pose.heading),
      .cos_val   (cos_val),
      .sin_val   (sin_val),
      .loop_more (loop_more)
   );

   ddpi_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .load            (accept),
      .req_op          (op_type'(req_tuser)),
      .req_lin_vel     (req_tdata[15:0]),
      .req_ang_vel     (req_tdata[31:16]),
      .req_new_x       (req_tdata[63:32]),
      .req_new_y       (req_tdata[95:64]),
      .req_new_heading (req_tdata[111:96]),
      .req_stop_value  (req_tdata[112]),
      .csr_we          (csr_valid & csr_ready),
      .csr_idx         (csr_index),
      .csr_wdata       (csr_data),
      .ctrl            (ctrl),
      .cos_val         (cos_val),
      .sin_val         (sin_val),
      .pose            (pose),
      .cur_op          (cur_op),
      .not_move        (not_move)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (done_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (done_fire) begin
         rsp_data_ff <= {7'b0000000, pose.halted, pose.heading, pose.y, pose.x};
         rsp_user_ff <= cur_op;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("sequencer not busy after request accept");

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_fire |=> (!busy && rsp_tvalid))
      else $error("result not posted or sequencer still busy after done");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (busy && ctrl.done && !out_free) |=> (busy && ctrl.done))
      else $error("final step left while result register full");

endmodule

// ===== verif/testbench.sv =====
module testbench;
   import ddpi_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = 8'hFF;

   typedef struct {
      op_type             op;
      logic signed [15:0] lin_vel;
      logic signed [15:0] ang_vel;
      logic signed [31:0] new_x;
      logic signed [31:0] new_y;
      logic [15:0]        new_heading;
      logic               stop_value;
   } pose_request_type;

   typedef struct {
      pose_type pose;
      op_type   op;
   } pose_result_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [119:0] req_tdata = '0;
   logic [1:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [87:0]  rsp_tdata;
   logic [1:0]   rsp_tuser;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [7:0]   csr_index = '0;
   logic [31:0]  csr_data = '0;

   diff_drive_pose_integrator_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // shadow of the csr registers and the tracked pose
   logic [15:0]        cfg_step_time = STEP_TIME_RESET;
   logic signed [31:0] cfg_init_x = '0;
   logic signed [31:0] cfg_init_y = '0;
   logic [15:0]        cfg_init_heading = '0;
   pose_type           odo = '0;

   int atan_step [14] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10, 5, 3, 1};

   pose_request_type pending_requests[$];
   pose_result_type  pose_expect[$];
   pose_request_type cur_request;
   pose_result_type  got_expect;
   int            issued = 0;
   int            accepted = 0;
   int            errors = 0;
   int            sender_gap = 0;
   int            sender_gap_pct = 0;
   int            rsp_hold = 0;
   int            rsp_stall_pct = 0;

   function automatic pose_type advance_pose(input pose_request_type r);
      longint   x, y, z, xs, ys, c, s, vdt, dx, dy, dh, px, py;
      logic [15:0] hf;
      bit       flip;
      case (r.op)
         OP_TICK: begin
            if (!odo.halted) begin
               z = longint'($signed(odo.heading));
               flip = 1'b0;
               if (z > 16384 || z < -16384) begin
                  hf = odo.heading + 16'h8000;
                  z = longint'($signed(hf));
                  flip = 1'b1;
               end
               x = 19898;
               y = 0;
               for (int i = 0; i < CORDIC_STEPS; i++) begin
                  xs = x >>> i;
                  ys = y >>> i;
                  if (z >= 0) begin
                     x = x - ys;
                     y = y + xs;
                     z = z - atan_step[i];
                  end else begin
                     x = x + ys;
                     y = y - xs;
                     z = z + atan_step[i];
                  end
               end
               if (flip) begin
                  x = -x;
                  y = -y;
               end
               c = (x > 32767) ? 32767 : ((x < -32767) ? -32767 : x);
               s = (y > 32767) ? 32767 : ((y < -32767) ? -32767 : y);
               vdt = longint'(r.lin_vel) * longint'(cfg_step_time);
               dx = (c * vdt + (64'sd1 <<< 26)) >>> 27;
               dy = (s * vdt + (64'sd1 <<< 26)) >>> 27;
               dh = (longint'(r.ang_vel) * longint'(cfg_step_time) * 64'sd683565277
                     + (64'sd1 <<< 43)) >>> 44;
               px = longint'(odo.x) + dx;
               py = longint'(odo.y) + dy;
               if (px > 64'sd2147483647) px = 64'sd2147483647;
               if (px < -64'sd2147483648) px = -64'sd2147483648;
               if (py > 64'sd2147483647) py = 64'sd2147483647;
               if (py < -64'sd2147483648) py = -64'sd2147483648;
               odo.x = px[31:0];
               odo.y = py[31:0];
               odo.heading = odo.heading + dh[15:0];
            end
         end
         OP_RESET: begin
            odo.x = cfg_init_x;
            odo.y = cfg_init_y;
            odo.heading = cfg_init_heading;
         end
         OP_SET_POSE: begin
            odo.x = r.new_x;
            odo.y = r.new_y;
            odo.heading = r.new_heading;
         end
         default: odo.halted = r.stop_value;
      endcase
      return odo;
   endfunction

   // csr writes land in the shadow registers
   always @(posedge clock) begin
      if (!reset && csr_valid && csr_ready) begin
         case (csr_index)
            CSR_STEP_TIME:       cfg_step_time <= csr_data[15:0];
            CSR_INITIAL_X:       cfg_init_x <= csr_data;
            CSR_INITIAL_Y:       cfg_init_y <= csr_data;
            CSR_INITIAL_HEADING: cfg_init_heading <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         sender_gap = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            got_expect.pose = advance_pose(cur_request);
            got_expect.op = cur_request.op;
            pose_expect.push_back(got_expect);
            accepted++;
         end
         if (!req_tvalid || req_tready) begin
            if (sender_gap > 0) begin
               sender_gap--;
               req_tvalid <= 1'b0;
            end else if (pending_requests.size() > 0
                         && $urandom_range(0, 99) < sender_gap_pct) begin
               sender_gap = $urandom_range(1, 16) - 1;
               req_tvalid <= 1'b0;
            end else if (pending_requests.size() > 0) begin
               cur_request = pending_requests.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= {7'b0, cur_request.stop_value, cur_request.new_heading,
                             cur_request.new_y, cur_request.new_x,
                             cur_request.ang_vel, cur_request.lin_vel};
               req_tuser <= cur_request.op;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         errors++;
      end
   endtask

   pose_result_type pose_want;

   // response monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pose_expect.size() == 0) begin
               $display("%0t: response with nothing pending, expected none, actual %h %h",
                        $time, rsp_tuser, rsp_tdata);
               errors++;
            end else begin
               pose_want = pose_expect.pop_front();
               check_field("pos_x", pose_want.pose.x, rsp_tdata[31:0]);
               check_field("pos_y", pose_want.pose.y, rsp_tdata[63:32]);
               check_field("heading", pose_want.pose.heading, rsp_tdata[79:64]);
               check_field("is_stopped", pose_want.pose.halted, rsp_tdata[80]);
               check_field("done_op", pose_want.op, rsp_tuser);
            end
         end
         if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_tready <= 1'b0;
         end else if ($urandom_range(0, 99) < rsp_stall_pct) begin
            rsp_hold = $urandom_range(1, 16) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic add_request(input op_type op, input logic [15:0] lin, input logic [15:0] ang,
                              input logic [31:0] x, input logic [31:0] y,
                              input logic [15:0] h, input logic stop);
      pose_request_type r;
      r.op = op;
      r.lin_vel = lin;
      r.ang_vel = ang;
      r.new_x = x;
      r.new_y = y;
      r.new_heading = h;
      r.stop_value = stop;
      pending_requests.push_back(r);
      issued++;
   endtask

   function automatic logic [15:0] pick_velocity();
      case ($urandom_range(0, 9))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return 16'h0000;
         3, 4, 5: return 16'($signed($urandom_range(0, 4095)) - 2048);
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [31:0] pick_position();
      case ($urandom_range(0, 11))
         0: return 32'h7FFFFFFF;
         1: return 32'h80000000;
         2: return 32'h7FFF0000;
         3: return 32'h80010000;
         4: return 32'h00000000;
         default: return $urandom;
      endcase
   endfunction

   task automatic add_random_requests(input int count);
      int kind;
      for (int n = 0; n < count; n++) begin
         kind = $urandom_range(0, 99);
         if (kind < 65)
            add_request(OP_TICK, pick_velocity(), pick_velocity(), $urandom, $urandom,
                        16'($urandom), 1'($urandom));
         else if (kind < 77)
            add_request(OP_SET_POSE, 16'($urandom), 16'($urandom), pick_position(),
                        pick_position(), 16'($urandom), 1'($urandom));
         else if (kind < 87)
            add_request(OP_RESET, 16'($urandom), 16'($urandom), $urandom, $urandom,
                        16'($urandom), 1'($urandom));
         else
            add_request(OP_SET_STOP, 16'($urandom), 16'($urandom), $urandom, $urandom,
                        16'($urandom), $urandom_range(0, 3) == 0);
      end
   endtask

   task automatic drain();
      do @(negedge clock); while (accepted != issued || pose_expect.size() != 0);
   endtask

   task automatic run_batch(input int count, input int gap_pct, input int stall_pct);
      sender_gap_pct = gap_pct;
      rsp_stall_pct = stall_pct;
      add_random_requests(count);
      drain();
   endtask

   task automatic write_reg(input logic [7:0] idx, input logic [31:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed requests on the reset configuration
      sender_gap_pct = 20;
      rsp_stall_pct = 20;
      add_request(OP_TICK, 16'h0000, 16'h0000, $urandom, $urandom, 16'($urandom), 1'b1);
      add_request(OP_TICK, 16'h7FFF, 16'h7FFF, $urandom, $urandom, 16'($urandom), 1'b1);
      add_request(OP_TICK, 16'h8000, 16'h8000, $urandom, $urandom, 16'($urandom), 1'b1);
      add_request(OP_SET_POSE, 16'hFFFF, 16'hFFFF, 32'h7FFFFFFF, 32'h80000000, 16'hFFFF, 1'b1);
      add_request(OP_TICK, 16'h7FFF, 16'h0000, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF, 1'b1);
      add_request(OP_TICK, 16'h8000, 16'h0000, $urandom, $urandom, 16'($urandom), 1'b0);
      add_request(OP_SET_POSE, 16'h0000, 16'h0000, 32'h80000000, 32'h7FFFFFFF, 16'h4000, 1'b0);
      add_request(OP_TICK, 16'h7FFF, 16'h7FFF, $urandom, $urandom, 16'($urandom), 1'b0);
      add_request(OP_SET_POSE, 16'h0000, 16'h0000, 32'h0, 32'h0, 16'h4001, 1'b0);
      add_request(OP_TICK, 16'h7FFF, 16'h0000, $urandom, $urandom, 16'($urandom), 1'b0);
      add_request(OP_SET_POSE, 16'h0000, 16'h0000, 32'h0, 32'h0, 16'hC000, 1'b0);
      add_request(OP_TICK, 16'h7FFF, 16'h0000, $urandom, $urandom, 16'($urandom), 1'b0);
      add_request(OP_SET_POSE, 16'h0000, 16'h0000, 32'h0, 32'h0, 16'hBFFF, 1'b0);
      add_request(OP_TICK, 16'h8000, 16'h0000, $urandom, $urandom, 16'($urandom), 1'b0);
      add_request(OP_SET_POSE, 16'h0000, 16'h0000, 32'h0, 32'h0, 16'h8000, 1'b0);
      add_request(OP_TICK, 16'h7FFF, 16'h8000, $urandom, $urandom, 16'($urandom), 1'b0);
      add_request(OP_SET_STOP, 16'($urandom), 16'($urandom), $urandom, $urandom,
                  16'($urandom), 1'b1);
      add_request(OP_TICK, 16'h7FFF, 16'h7FFF, $urandom, $urandom, 16'($urandom), 1'b0);
      add_request(OP_RESET, 16'hFFFF, 16'hFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF, 1'b1);
      add_request(OP_TICK, 16'h8000, 16'h8000, $urandom, $urandom, 16'($urandom), 1'b0);
      add_request(OP_SET_STOP, 16'($urandom), 16'($urandom), $urandom, $urandom,
                  16'($urandom), 1'b0);
      add_request(OP_TICK, 16'h1234, 16'hFEDC, $urandom, $urandom, 16'($urandom), 1'b1);
      run_batch(180, 20, 20);

      // extreme configuration, long receiver hold-off with the sender still offering
      write_reg(CSR_STEP_TIME, 32'h0000FFFF);
      write_reg(CSR_INITIAL_X, 32'h7FFFFFFF);
      write_reg(CSR_INITIAL_Y, 32'h80000000);
      write_reg(CSR_INITIAL_HEADING, 32'h0000FFFF);
      write_reg(CSR_UNMAPPED, 32'hFFFFFFFF);
      @(negedge clock);
      rsp_hold = 400;
      run_batch(220, 0, 10);

      write_reg(CSR_STEP_TIME, 32'h00000001);
      write_reg(CSR_INITIAL_X, 32'h80000000);
      write_reg(CSR_INITIAL_Y, 32'h7FFFFFFF);
      write_reg(CSR_INITIAL_HEADING, 32'h00000000);
      run_batch(170, 40, 40);

      // zero step time
      write_reg(CSR_STEP_TIME, 32'h00000000);
      write_reg(CSR_INITIAL_X, $urandom);
      write_reg(CSR_INITIAL_Y, $urandom);
      write_reg(CSR_INITIAL_HEADING, $urandom_range(0, 65535));
      run_batch(120, 15, 30);

      write_reg(CSR_STEP_TIME, $urandom_range(1, 65535));
      write_reg(CSR_INITIAL_X, $urandom);
      write_reg(CSR_INITIAL_Y, $urandom);
      write_reg(CSR_INITIAL_HEADING, $urandom_range(0, 65535));
      run_batch(260, 30, 15);

      // no idling at the end
      write_reg(CSR_STEP_TIME, STEP_TIME_RESET);
      write_reg(CSR_INITIAL_HEADING, $urandom_range(0, 65535));
      run_batch(230, 0, 0);

      repeat (40) @(posedge clock);
      if (errors == 0)
         $display("testbench: done, clean");
      else
         $display("testbench: done, errors");
      $finish;
   end

   initial begin
      #4000000;
      $display("testbench: done, errors");
      $finish;
   end

endmodule

// ===== files.f =====
hdl/ddpi_pkg.sv
hdl/ddpi_seq.sv
hdl/ddpi_cordic.sv
hdl/ddpi_dp.sv
hdl/diff_drive_pose_integrator_unit.sv
verif/testbench.sv
